### hw/rtl/frt_pkg.sv
`timescale 1ns / 1ps

package frt_pkg;

  localparam int TAP_COUNT_W = 7;
  localparam int COEF_IDX_W  = 6;
  localparam int REG_IDX_W   = 2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_TAP_COUNT    = 2'd0;
  localparam reg_idx_t REG_COEF_INDEX   = 2'd1;
  localparam reg_idx_t REG_COEF_VALUE   = 2'd2;
  localparam reg_idx_t REG_COMPLEX_MODE = 2'd3;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd1;
  localparam logic                   COMPLEX_RST   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // control that every cell of the chain sees
  typedef struct packed {
    logic                   shift;
    logic                   coef_we;
    logic [COEF_IDX_W-1:0]  coef_idx;
    logic [TAP_COUNT_W-1:0] tap_count;
  } cell_ctl_t;

endpackage

### hw/rtl/frt_if.sv
`timescale 1ns / 1ps

interface frt_in_if #(
  parameter int SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample_i;
  logic signed [SW-1:0] sample_q;

  modport source (output valid, output sample_i, output sample_q, input ready);
  modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface frt_out_if #(
  parameter int SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] out_i;
  logic signed [SW-1:0] out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink (input valid, input out_i, input out_q, output ready);
endinterface

interface frt_cfg_if #(
  parameter int DW = 16
);
  logic                     valid;
  logic                     ready;
  logic [frt_pkg::REG_IDX_W-1:0] index;
  logic [DW-1:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/fir_filter_real_taps_unit.sv
`timescale 1ns / 1ps

// streaming fir filter, real coefficients, i/q filtered alike
// in_ch: one sample item (sample_i, sample_q), taken when valid and ready
// out_ch: one filtered item (out_i, out_q) for each input item, in order
// cfg_ch: register writes, index 0 tap_count, 1 coef_index, 2 coef_value
//   (stored into the slot given by coef_index), 3 complex_mode; always ready,
//   write only while no item is in flight
// a row of MAX_TAPS cells holds the delay line and the coefficients; each
// cell registers its product and adds it to the partial sum from its left
// neighbor, so the sum ripples down the row one cell per cycle
// an accepted sample enters the delay line, each cell registers its product and
// the sum ripples through the whole row, independent of tap_count; it is then
// rounded, saturated and loaded into the output register, and only after that load
// the next item is taken while a finished result waits in the output register;
// if the receiver stalls longer, the block holds the following sum in the row
// reset: delay line and coefficients cleared, tap_count 1, coef_index 0,
// complex_mode 1, output empty
module fir_filter_real_taps_unit #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  frt_in_if.sink           in_ch,
  frt_out_if.source        out_ch,
  frt_cfg_if.sink          cfg_ch
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = COEF_WIDTH;
  localparam int ACC_W  = SW + CW + $clog2(MAX_TAPS) + 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 2);
  localparam logic [CNT_W-1:0] DONE_CNT = CNT_W'(MAX_TAPS + 1);
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (CW - 2);
  localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) << (SW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

  frt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [frt_pkg::TAP_COUNT_W-1:0] tap_count_r;
  logic [frt_pkg::COEF_IDX_W-1:0]  coef_index_r;
  logic                            complex_mode_r;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_i_r, out_q_r;
  logic signed [SW-1:0] sat_i, sat_q;
  logic                 load;
  logic                 in_acc;
  logic                 cfg_acc;

  frt_pkg::cell_ctl_t   ctl;
  logic signed [SW-1:0] new_q;

  logic signed [SW-1:0]    x_i [MAX_TAPS];
  logic signed [SW-1:0]    x_q [MAX_TAPS];
  logic signed [ACC_W-1:0] sum_i [MAX_TAPS];
  logic signed [ACC_W-1:0] sum_q [MAX_TAPS];

  logic signed [ACC_W-1:0] rnd_i, rnd_q, sh_i, sh_q;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r    <= frt_pkg::TAP_COUNT_RST;
      coef_index_r   <= '0;
      complex_mode_r <= frt_pkg::COMPLEX_RST;
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        frt_pkg::REG_TAP_COUNT:    tap_count_r    <= cfg_ch.data[frt_pkg::TAP_COUNT_W-1:0];
        frt_pkg::REG_COEF_INDEX:   coef_index_r   <= cfg_ch.data[frt_pkg::COEF_IDX_W-1:0];
        frt_pkg::REG_COMPLEX_MODE: complex_mode_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == frt_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign new_q       = complex_mode_r ? in_ch.sample_q : '0;

  assign ctl.shift     = in_acc;
  assign ctl.coef_we   = cfg_acc && (cfg_ch.index == frt_pkg::REG_COEF_VALUE);
  assign ctl.coef_idx  = coef_index_r;
  assign ctl.tap_count = tap_count_r;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      frt_cell #(.K(k), .SW(SW), .CW(CW), .ACC_W(ACC_W)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .coef_wdata (cfg_ch.data[CW-1:0]),
        .x_i_in     (in_ch.sample_i),
        .x_q_in     (new_q),
        .sum_i_in   ('0),
        .sum_q_in   ('0),
        .x_i_r      (x_i[k]),
        .x_q_r      (x_q[k]),
        .sum_i_r    (sum_i[k]),
        .sum_q_r    (sum_q[k])
      );
    end else begin : g_body
      frt_cell #(.K(k), .SW(SW), .CW(CW), .ACC_W(ACC_W)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .coef_wdata (cfg_ch.data[CW-1:0]),
        .x_i_in     (x_i[k-1]),
        .x_q_in     (x_q[k-1]),
        .sum_i_in   (sum_i[k-1]),
        .sum_q_in   (sum_q[k-1]),
        .x_i_r      (x_i[k]),
        .x_q_r      (x_q[k]),
        .sum_i_r    (sum_i[k]),
        .sum_q_r    (sum_q[k])
      );
    end
  end

  // round half up, drop the coefficient fraction, saturate
  always_comb begin
    rnd_i = sum_i[MAX_TAPS-1] + RND;
    rnd_q = sum_q[MAX_TAPS-1] + RND;
    sh_i  = rnd_i >>> (CW - 1);
    sh_q  = rnd_q >>> (CW - 1);
    if (sh_i > MAXV) begin
      sat_i = MAXV[SW-1:0];
    end else if (sh_i < MINV) begin
      sat_i = MINV[SW-1:0];
    end else begin
      sat_i = sh_i[SW-1:0];
    end
    if (sh_q > MAXV) begin
      sat_q = MAXV[SW-1:0];
    end else if (sh_q < MINV) begin
      sat_q = MINV[SW-1:0];
    end else begin
      sat_q = sh_q[SW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    load      = 1'b0;
    unique case (state_r)
      frt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = frt_pkg::ST_RUN;
          cnt_nxt   = '0;
        end
      end
      frt_pkg::ST_RUN: begin
        if (cnt_r == DONE_CNT) begin
          // sum is settled at the end of the row; wait for room at the output
          if (!out_valid_r || out_ch.ready) begin
            load      = 1'b1;
            state_nxt = frt_pkg::ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = frt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_i_r <= sat_i;
      out_q_r <= complex_mode_r ? sat_q : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_i = out_i_r;
  assign out_ch.out_q = out_q_r;

endmodule

### hw/rtl/frt_cell.sv
`timescale 1ns / 1ps

module frt_cell #(
  parameter int K     = 0,
  parameter int SW    = 16,
  parameter int CW    = 16,
  parameter int ACC_W = 39
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  frt_pkg::cell_ctl_t      ctl,
  input  logic signed [CW-1:0]    coef_wdata,
  input  logic signed [SW-1:0]    x_i_in,
  input  logic signed [SW-1:0]    x_q_in,
  input  logic signed [ACC_W-1:0] sum_i_in,
  input  logic signed [ACC_W-1:0] sum_q_in,
  output logic signed [SW-1:0]    x_i_r,
  output logic signed [SW-1:0]    x_q_r,
  output logic signed [ACC_W-1:0] sum_i_r,
  output logic signed [ACC_W-1:0] sum_q_r
);

  localparam int PW = SW + CW;

  logic signed [CW-1:0] coef_r;
  logic signed [PW-1:0] prod_i_r;
  logic signed [PW-1:0] prod_q_r;
  logic signed [PW-1:0] prod_i_nxt;
  logic signed [PW-1:0] prod_q_nxt;
  logic                 active;
  logic                 idx_hit;

  // tap count zero still uses the first tap
  assign active  = (K == 0) || (K < 32'(ctl.tap_count));
  assign idx_hit = (32'(ctl.coef_idx) == K);

  always_comb begin
    prod_i_nxt = '0;
    prod_q_nxt = '0;
    if (active) begin
      prod_i_nxt = PW'(x_i_r) * PW'(coef_r);
      prod_q_nxt = PW'(x_q_r) * PW'(coef_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_i_r  <= '0;
      x_q_r  <= '0;
      coef_r <= '0;
    end else begin
      if (ctl.shift) begin
        x_i_r <= x_i_in;
        x_q_r <= x_q_in;
      end
      if (ctl.coef_we && idx_hit) begin
        coef_r <= coef_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_i_r <= prod_i_nxt;
    prod_q_r <= prod_q_nxt;
    sum_i_r  <= sum_i_in + ACC_W'(prod_i_r);
    sum_q_r  <= sum_q_in + ACC_W'(prod_q_r);
  end

endmodule

### hw/rtl/frt_checker.sv
`timescale 1ns / 1ps

module frt_checker #(
  parameter int SW = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [SW-1:0] out_i,
  input logic [SW-1:0] out_q
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_i) && $stable(out_q))
    else $error("result item changed while stalled");

  // one item in the cell row at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while the row is busy");

  // a new result only appears at the end of a busy period
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result item appeared without a computation");

endmodule

bind fir_filter_real_taps_unit frt_checker #(.SW(SAMPLE_WIDTH)) u_frt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_i     (out_ch.out_i),
  .out_q     (out_ch.out_q)
);
